[design/obss_pkg.sv]
// ----------------------------------------------------------------------------
// obss_pkg: shared types and codes for the oriented block scan stepper
// Request/response payloads, configuration bundle, position state and codes.
// ----------------------------------------------------------------------------
package obss_pkg;

   localparam int unsigned COORD_W   = 16;
   localparam int unsigned BLOCK_W   = 9;
   localparam int unsigned MODE_W    = 3;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 16;
   // full precision for sums and compares
   localparam int unsigned CALC_W    = 18;

   typedef enum logic [1:0] {
      OP_MOVE_FIRST = 2'd0,
      OP_MOVE_NEXT  = 2'd1,
      OP_SET_END    = 2'd2
   } op_type;

   typedef enum logic [MODE_W-1:0] {
      ORIENT_NORMAL      = 3'd0,
      ORIENT_ROT90       = 3'd1,
      ORIENT_HFLIP       = 3'd2,
      ORIENT_VFLIP       = 3'd3,
      ORIENT_ROT180      = 3'd4,
      ORIENT_ROT270      = 3'd5,
      ORIENT_HFLIP_ROT90 = 3'd6,
      ORIENT_VFLIP_ROT90 = 3'd7
   } orient_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_LEFT       = 3'd0,
      CSR_FRAME_TOP        = 3'd1,
      CSR_FRAME_RIGHT      = 3'd2,
      CSR_FRAME_BOTTOM     = 3'd3,
      CSR_BLOCK_WIDTH      = 3'd4,
      CSR_BLOCK_HEIGHT     = 3'd5,
      CSR_ORIENTATION_MODE = 3'd6
   } csr_idx_type;

   localparam logic [BLOCK_W-1:0] BLOCK_W_RESET = 9'd8;
   localparam logic [BLOCK_W-1:0] BLOCK_H_RESET = 9'd8;

   typedef struct packed {
      logic [1:0] opcode;
      logic       end_value;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic                      end_of_image;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] frame_left;
      logic signed [COORD_W-1:0] frame_top;
      logic signed [COORD_W-1:0] frame_right;
      logic signed [COORD_W-1:0] frame_bottom;
      logic [BLOCK_W-1:0]        block_width;
      logic [BLOCK_W-1:0]        block_height;
      logic [MODE_W-1:0]         orientation_mode;
   } cfg_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] cur_x;
      logic signed [COORD_W-1:0] cur_y;
      logic                      end_flag;
   } pos_type;

endpackage

[design/obss_step.sv]
// ----------------------------------------------------------------------------
// obss_step: next-position logic
// Computes the position and end flag that one request leaves behind.
// ----------------------------------------------------------------------------
module obss_step (
   input  obss_pkg::cfg_type cfg,
   input  obss_pkg::pos_type cur,
   input  obss_pkg::req_type req,
   output obss_pkg::pos_type nxt
);
   import obss_pkg::*;

   logic signed [CALC_W-1:0] l, t, r, b, bw, bh, x, y;
   logic signed [CALC_W-1:0] x_pbw, x_mbw, y_pbh, y_mbh, y_p2bh, r_mbw, b_mbh;
   logic signed [CALC_W-1:0] first_x, first_y, step_x, step_y;
   logic                     fin;

   assign l  = CALC_W'(cfg.frame_left);
   assign t  = CALC_W'(cfg.frame_top);
   assign r  = CALC_W'(cfg.frame_right);
   assign b  = CALC_W'(cfg.frame_bottom);
   assign bw = $signed({{(CALC_W-BLOCK_W){1'b0}}, cfg.block_width});
   assign bh = $signed({{(CALC_W-BLOCK_W){1'b0}}, cfg.block_height});
   assign x  = CALC_W'(cur.cur_x);
   assign y  = CALC_W'(cur.cur_y);

   assign x_pbw  = x + bw;
   assign x_mbw  = x - bw;
   assign y_pbh  = y + bh;
   assign y_mbh  = y - bh;
   assign y_p2bh = y_pbh + bh;
   assign r_mbw  = r - bw;
   assign b_mbh  = b - bh;

   // start corner
   always_comb begin
      case (cfg.orientation_mode)
         ORIENT_ROT90, ORIENT_HFLIP: begin
            first_x = l;
            first_y = b_mbh;
         end
         ORIENT_VFLIP, ORIENT_ROT270: begin
            first_x = r_mbw;
            first_y = t;
         end
         ORIENT_ROT180, ORIENT_HFLIP_ROT90: begin
            first_x = r_mbw;
            first_y = b_mbh;
         end
         default: begin
            first_x = l;
            first_y = t;
         end
      endcase
   end

   // one step, wrap to next row or column, or flag the end
   always_comb begin
      step_x = x;
      step_y = y;
      fin    = 1'b0;
      case (cfg.orientation_mode)
         ORIENT_NORMAL: begin
            step_x = x_pbw;
            if (x_pbw >= r) begin
               if (y_pbh >= b) begin
                  fin = 1'b1;
               end else begin
                  step_x = l;
                  step_y = y_pbh;
               end
            end
         end
         ORIENT_ROT90: begin
            step_y = y_mbh;
            if (y_mbh < t) begin
               if (x_pbw >= r) begin
                  fin = 1'b1;
               end else begin
                  step_y = b_mbh;
                  step_x = x_pbw;
               end
            end
         end
         ORIENT_HFLIP: begin
            step_x = x_pbw;
            if (x_pbw >= r) begin
               if (y <= t) begin
                  fin = 1'b1;
               end else begin
                  step_x = l;
                  step_y = y_mbh;
               end
            end
         end
         ORIENT_VFLIP: begin
            step_x = x_mbw;
            if (x_mbw < l) begin
               if (y_pbh >= b) begin
                  fin = 1'b1;
               end else begin
                  step_x = r_mbw;
                  step_y = y_pbh;
               end
            end
         end
         ORIENT_ROT180: begin
            step_x = x_mbw;
            if (x_mbw < l) begin
               if (y_mbh < t) begin
                  fin = 1'b1;
               end else begin
                  step_x = r_mbw;
                  step_y = y_mbh;
               end
            end
         end
         ORIENT_ROT270: begin
            step_y = y_pbh;
            if (y_p2bh > b) begin
               if (x <= l) begin
                  fin = 1'b1;
               end else begin
                  step_y = t;
                  step_x = x_mbw;
               end
            end
         end
         ORIENT_HFLIP_ROT90: begin
            step_y = y_mbh;
            if (y_mbh < t) begin
               if (x_mbw < l) begin
                  fin = 1'b1;
               end else begin
                  step_y = b_mbh;
                  step_x = x_mbw;
               end
            end
         end
         default: begin
            step_y = y_pbh;
            if (y_p2bh > b) begin
               if (x_pbw >= r) begin
                  fin = 1'b1;
               end else begin
                  step_y = t;
                  step_x = x_pbw;
               end
            end
         end
      endcase
   end

   always_comb begin
      nxt = cur;
      case (req.opcode)
         OP_MOVE_FIRST: begin
            nxt.cur_x = first_x[COORD_W-1:0];
            nxt.cur_y = first_y[COORD_W-1:0];
         end
         OP_MOVE_NEXT: begin
            nxt.cur_x    = step_x[COORD_W-1:0];
            nxt.cur_y    = step_y[COORD_W-1:0];
            nxt.end_flag = cur.end_flag | fin;
         end
         OP_SET_END: begin
            nxt.end_flag = req.end_value;
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

[design/obss_rsp_skid.sv]
// ----------------------------------------------------------------------------
// obss_rsp_skid: response output register with skid stage
// Holds one response at the port and one more behind it.
// ----------------------------------------------------------------------------
module obss_rsp_skid (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  obss_pkg::rsp_type in_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output obss_pkg::rsp_type rsp_payload
);
   import obss_pkg::*;

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_data_ff, out_data_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    in_xfer, out_xfer;

   assign in_ready    = !skid_valid_ff;
   assign in_xfer     = in_valid && in_ready;
   assign out_xfer    = out_valid_ff && rsp_ready;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         // drain the skid stage into the port
         if (out_xfer) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_xfer) begin
         if (!out_valid_ff || out_xfer) begin
            out_valid_in = 1'b1;
            out_data_in  = in_payload;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = in_payload;
         end
      end else if (out_xfer) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

`ifndef ASSERT_OFF
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage holds data while output register is empty");

   a_skid_fills_on_stall: assert property (@(posedge clock) disable iff (reset)
      in_xfer && out_valid_ff && !rsp_ready |=> skid_valid_ff)
      else $error("transfer during stall not captured in skid stage");

   a_out_held_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");
`endif

endmodule

[design/oriented_block_scan_stepper_unit.sv]
// ----------------------------------------------------------------------------
// oriented_block_scan_stepper_unit: block position walker, eight orientations
// Steps block positions across a frame rectangle in the selected orientation.
// ----------------------------------------------------------------------------
//   channel   ports                                       direction
//   req       req_valid, req_ready, req_payload           in  (opcode, end_value)
//   rsp       rsp_valid, rsp_ready, rsp_payload           out (pos_x, pos_y, end)
//   csr       csr_write_en, csr_index, csr_wdata          in  (write only)
//
// One request per cycle while req_ready is high; each response is registered
// in the output stage. The position registers update at each request transfer
// from one add, compare and select stage, so throughput is one item per clock
// while req_ready is high. A two-entry output stage keeps accepting while the
// response side stalls; req_ready drops only when both entries are full.
// Reset clears position and end flag and loads register defaults.
// ----------------------------------------------------------------------------
module oriented_block_scan_stepper_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  obss_pkg::req_type                    req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output obss_pkg::rsp_type                    rsp_payload,
   input  logic                                 csr_write_en,
   input  logic [obss_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [obss_pkg::CSR_DAT_W-1:0]       csr_wdata
);
   import obss_pkg::*;

   cfg_type cfg_ff, cfg_in;
   pos_type pos_ff, pos_in, pos_step;
   rsp_type rsp_new;
   logic    req_xfer;
   logic    end_clear;

   assign req_xfer = req_valid && req_ready;

   obss_step u_step (
      .cfg (cfg_ff),
      .cur (pos_ff),
      .req (req_payload),
      .nxt (pos_step)
   );

   always_comb begin
      cfg_in    = cfg_ff;
      end_clear = 1'b0;
      if (csr_write_en) begin
         case (csr_index)
            CSR_FRAME_LEFT: begin
               cfg_in.frame_left = csr_wdata;
               end_clear         = 1'b1;
            end
            CSR_FRAME_TOP: begin
               cfg_in.frame_top = csr_wdata;
               end_clear        = 1'b1;
            end
            CSR_FRAME_RIGHT: begin
               cfg_in.frame_right = csr_wdata;
               end_clear          = 1'b1;
            end
            CSR_FRAME_BOTTOM: begin
               cfg_in.frame_bottom = csr_wdata;
               end_clear           = 1'b1;
            end
            CSR_BLOCK_WIDTH: begin
               cfg_in.block_width = csr_wdata[BLOCK_W-1:0];
               end_clear          = 1'b1;
            end
            CSR_BLOCK_HEIGHT: begin
               cfg_in.block_height = csr_wdata[BLOCK_W-1:0];
               end_clear           = 1'b1;
            end
            CSR_ORIENTATION_MODE: begin
               cfg_in.orientation_mode = csr_wdata[MODE_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      pos_in = pos_ff;
      if (req_xfer) begin
         pos_in = pos_step;
      end else if (end_clear) begin
         pos_in.end_flag = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_left       <= '0;
         cfg_ff.frame_top        <= '0;
         cfg_ff.frame_right      <= '0;
         cfg_ff.frame_bottom     <= '0;
         cfg_ff.block_width      <= BLOCK_W_RESET;
         cfg_ff.block_height     <= BLOCK_H_RESET;
         cfg_ff.orientation_mode <= ORIENT_NORMAL;
         pos_ff                  <= '0;
      end else begin
         cfg_ff <= cfg_in;
         pos_ff <= pos_in;
      end
   end

   assign rsp_new.pos_x        = pos_step.cur_x;
   assign rsp_new.pos_y        = pos_step.cur_y;
   assign rsp_new.end_of_image = pos_step.end_flag;

   obss_rsp_skid u_rsp (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .in_payload  (rsp_new),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

`ifndef ASSERT_OFF
   a_set_end_lands: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_payload.opcode == OP_SET_END
      |=> pos_ff.end_flag == $past(req_payload.end_value))
      else $error("end flag write not taken");

   a_csr_clears_end: assert property (@(posedge clock) disable iff (reset)
      !req_xfer && end_clear |=> !pos_ff.end_flag)
      else $error("dimension write did not clear end flag");

   a_ready_when_idle: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request blocked with the output stage empty");
`endif

endmodule

[tb/tb_oriented_block_scan_stepper_unit.sv]
// ----------------------------------------------------------------------------
// tb_oriented_block_scan_stepper_unit: self-checking bench for the block walker
// Drives move-first, move-next, end-flag and unused commands through random
// frame, block and orientation settings, predicts each position in the bench
// and compares every response field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_oriented_block_scan_stepper_unit;
   import obss_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int SHOWN_MAX   = 10;
   localparam logic [1:0]           OP_UNUSED      = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_IDX = 3'd7;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_payload;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_type              rsp_payload;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;

   // bench copy of the registers and the walk position
   cfg_type frame_cfg;
   pos_type walk_pos;
   rsp_type expected_pos[$];

   bit steady;
   int cycle_count;
   int errors;
   int items_sent;
   int results_checked;
   int csr_writes;
   int walks_done;

   oriented_block_scan_stepper_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  expected_pos.size());
         $display("** oriented_block_scan_stepper_unit: FAILED **");
         $finish;
      end
   end

   // mostly short gaps, a few long ones; none during steady stretches
   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [15:0] pick_coord();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_block_raw();
      case ($urandom_range(0, 6))
         0: return 16'h0000;
         1: return 16'h0001;
         2: return 16'hFF00;   // 256 after masking
         3: return 16'hFFFF;   // 511 after masking
         default: return 16'($urandom);
      endcase
   endfunction

   // Advance the bench position for one transfer and queue the response.
   task automatic advance_position(input req_type rq);
      int l, t, r, b, bw, bh, x, y;
      bit fin;
      l = int'(frame_cfg.frame_left);
      t = int'(frame_cfg.frame_top);
      r = int'(frame_cfg.frame_right);
      b = int'(frame_cfg.frame_bottom);
      bw = int'(frame_cfg.block_width);
      bh = int'(frame_cfg.block_height);
      x = int'(walk_pos.cur_x);
      y = int'(walk_pos.cur_y);
      fin = 1'b0;
      case (rq.opcode)
         OP_MOVE_FIRST: begin
            case (orient_type'(frame_cfg.orientation_mode))
               ORIENT_ROT90, ORIENT_HFLIP: begin
                  x = l;
                  y = b - bh;
               end
               ORIENT_VFLIP, ORIENT_ROT270: begin
                  x = r - bw;
                  y = t;
               end
               ORIENT_ROT180, ORIENT_HFLIP_ROT90: begin
                  x = r - bw;
                  y = b - bh;
               end
               default: begin
                  x = l;
                  y = t;
               end
            endcase
         end
         OP_MOVE_NEXT: begin
            case (orient_type'(frame_cfg.orientation_mode))
               ORIENT_NORMAL: begin
                  x += bw;
                  if (x >= r) begin
                     if (y + bh >= b) fin = 1'b1;
                     else begin x = l; y += bh; end
                  end
               end
               ORIENT_ROT90: begin
                  y -= bh;
                  if (y < t) begin
                     if (x + bw >= r) fin = 1'b1;
                     else begin y = b - bh; x += bw; end
                  end
               end
               ORIENT_HFLIP: begin
                  x += bw;
                  if (x >= r) begin
                     if (y <= t) fin = 1'b1;
                     else begin x = l; y -= bh; end
                  end
               end
               ORIENT_VFLIP: begin
                  x -= bw;
                  if (x < l) begin
                     if (y + bh >= b) fin = 1'b1;
                     else begin x = r - bw; y += bh; end
                  end
               end
               ORIENT_ROT180: begin
                  x -= bw;
                  if (x < l) begin
                     if (y - bh < t) fin = 1'b1;
                     else begin x = r - bw; y -= bh; end
                  end
               end
               ORIENT_ROT270: begin
                  y += bh;
                  if (y + bh > b) begin
                     if (x <= l) fin = 1'b1;
                     else begin y = t; x -= bw; end
                  end
               end
               ORIENT_HFLIP_ROT90: begin
                  y -= bh;
                  if (y < t) begin
                     if (x - bw < l) fin = 1'b1;
                     else begin y = b - bh; x -= bw; end
                  end
               end
               default: begin
                  y += bh;
                  if (y + bh > b) begin
                     if (x + bw >= r) fin = 1'b1;
                     else begin y = t; x += bw; end
                  end
               end
            endcase
            if (fin) walk_pos.end_flag = 1'b1;
         end
         OP_SET_END: walk_pos.end_flag = rq.end_value;
         default: ;
      endcase
      // full precision above, stored position wraps to 16 bits
      walk_pos.cur_x = x[15:0];
      walk_pos.cur_y = y[15:0];
      expected_pos.push_back('{pos_x: walk_pos.cur_x, pos_y: walk_pos.cur_y,
                               end_of_image: walk_pos.end_flag});
   endtask

   // Called at a falling edge; returns at the falling edge after the transfer
   // with valid still high, so a back-to-back item keeps it up.
   task automatic send_step(input logic [1:0] op, input logic ev);
      int gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_payload.opcode = op;
      req_payload.end_value = ev;
      do @(posedge clock); while (!req_ready);
      advance_position(req_payload);
      items_sent++;
      @(negedge clock);
   endtask

   // Drop valid and hold until every queued response has come back.
   task automatic wait_drained();
      req_valid = 1'b0;
      while (expected_pos.size() != 0) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DAT_W-1:0] data);
      csr_write_en = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      case (idx)
         CSR_FRAME_LEFT:       frame_cfg.frame_left = data;
         CSR_FRAME_TOP:        frame_cfg.frame_top = data;
         CSR_FRAME_RIGHT:      frame_cfg.frame_right = data;
         CSR_FRAME_BOTTOM:     frame_cfg.frame_bottom = data;
         CSR_BLOCK_WIDTH:      frame_cfg.block_width = data[BLOCK_W-1:0];
         CSR_BLOCK_HEIGHT:     frame_cfg.block_height = data[BLOCK_W-1:0];
         CSR_ORIENTATION_MODE: frame_cfg.orientation_mode = data[MODE_W-1:0];
         default: ;
      endcase
      // geometry writes restart the scan, mode writes do not
      if (idx <= CSR_BLOCK_HEIGHT) walk_pos.end_flag = 1'b0;
      csr_writes++;
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   task automatic set_frame(input logic [15:0] l, input logic [15:0] t,
                            input logic [15:0] r, input logic [15:0] b,
                            input logic [15:0] bw, input logic [15:0] bh);
      wait_drained();
      csr_write(CSR_FRAME_LEFT, l);
      csr_write(CSR_FRAME_TOP, t);
      csr_write(CSR_FRAME_RIGHT, r);
      csr_write(CSR_FRAME_BOTTOM, b);
      csr_write(CSR_BLOCK_WIDTH, bw);
      csr_write(CSR_BLOCK_HEIGHT, bh);
   endtask

   // response checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_checked++;
         if (expected_pos.size() == 0) begin
            errors++;
            if (errors <= SHOWN_MAX)
               $display("[%0t] unexpected response x=%0d y=%0d end=%0b", $time,
                        rsp_payload.pos_x, rsp_payload.pos_y,
                        rsp_payload.end_of_image);
         end else begin
            want = expected_pos.pop_front();
            if (rsp_payload.pos_x !== want.pos_x || rsp_payload.pos_y !== want.pos_y ||
                rsp_payload.end_of_image !== want.end_of_image) begin
               errors++;
               if (errors <= SHOWN_MAX)
                  $display("[%0t] response %0d: expected x=%0d y=%0d end=%0b, got x=%0d y=%0d end=%0b",
                           $time, results_checked, want.pos_x, want.pos_y,
                           want.end_of_image, rsp_payload.pos_x, rsp_payload.pos_y,
                           rsp_payload.end_of_image);
            end
         end
      end
   end

   // response side backpressure
   initial begin
      int stall;
      stall = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (steady) begin
            rsp_ready = 1'b1;
         end else if (stall > 0) begin
            rsp_ready = 1'b0;
            stall--;
         end else begin
            rsp_ready = 1'b1;
            if ($urandom_range(0, 3) == 0) stall = pick_gap();
         end
      end
   end

   // Reset state, unused opcode, end flag writes and register writes that leave it set.
   task automatic test_reset_defaults();
      send_step(OP_UNUSED, 1'b1);
      send_step(OP_MOVE_NEXT, 1'b0);
      send_step(OP_MOVE_FIRST, 1'b1);
      send_step(OP_SET_END, 1'b0);
      send_step(OP_SET_END, 1'b1);
      wait_drained();
      csr_write(CSR_UNUSED_IDX, 16'hFFFF);
      csr_write(CSR_ORIENTATION_MODE, 16'(ORIENT_ROT180));
      send_step(OP_UNUSED, 1'b0);
   endtask

   // Extreme frame and block sizes in all eight orientations, 16-bit wrap,
   // and a zero block that never leaves its row.
   task automatic test_extremes();
      orient_type m;
      set_frame(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'hFF00, 16'h0100);
      for (int i = 0; i < 8; i++) begin
         m = orient_type'(i);
         wait_drained();
         csr_write(CSR_ORIENTATION_MODE, 16'(m));
         send_step(OP_MOVE_FIRST, 1'b0);
         send_step(OP_MOVE_NEXT, 1'b1);
      end
      set_frame(16'h7FF8, 16'h7FF8, 16'h8000, 16'h8000, 16'd8, 16'd8);
      wait_drained();
      csr_write(CSR_ORIENTATION_MODE, 16'(ORIENT_NORMAL));
      send_step(OP_MOVE_FIRST, 1'b0);
      send_step(OP_MOVE_NEXT, 1'b0);
      set_frame(16'd0, 16'd0, 16'd16, 16'd16, 16'd0, 16'd0);
      send_step(OP_MOVE_NEXT, 1'b1);
   endtask

   // Complete scans over small random frames, with stray commands mixed in.
   task automatic test_scan_walks(input int item_goal);
      int start, bw, bh, ncol, nrow, steps, pick, l, t, r, b;
      start = items_sent;
      while (items_sent - start < item_goal) begin
         steady = (walks_done % 10 == 3);
         if (walks_done == 0 || $urandom_range(0, 5) != 0) begin
            bw = ($urandom_range(0, 9) == 0) ? 256 : $urandom_range(1, 24);
            bh = ($urandom_range(0, 9) == 0) ? 256 : $urandom_range(1, 24);
            ncol = $urandom_range(1, 4);
            nrow = $urandom_range(1, 4);
            l = ($urandom_range(0, 7) == 0) ? int'($urandom) : $urandom_range(0, 2000) - 1000;
            t = ($urandom_range(0, 7) == 0) ? int'($urandom) : $urandom_range(0, 2000) - 1000;
            r = l + bw * ncol + (($urandom_range(0, 3) == 0) ? $urandom_range(0, bw - 1) : 0);
            b = t + bh * nrow + (($urandom_range(0, 3) == 0) ? $urandom_range(0, bh - 1) : 0);
            set_frame(l[15:0], t[15:0], r[15:0], b[15:0], bw[15:0], bh[15:0]);
         end
         wait_drained();
         csr_write(CSR_ORIENTATION_MODE, 16'($urandom));
         send_step(OP_MOVE_FIRST, 1'($urandom_range(0, 1)));
         steps = 0;
         while (!walk_pos.end_flag && steps < 48) begin
            pick = $urandom_range(0, 24);
            if (pick == 0) send_step(OP_UNUSED, 1'($urandom_range(0, 1)));
            else if (pick == 1) send_step(OP_SET_END, 1'($urandom_range(0, 1)));
            else if (pick == 2) send_step(OP_MOVE_FIRST, 1'($urandom_range(0, 1)));
            else if (pick == 3 && !steady) wait_drained();
            else send_step(OP_MOVE_NEXT, 1'($urandom_range(0, 1)));
            steps++;
         end
         // keep stepping past the end for a little
         repeat ($urandom_range(0, 2)) send_step(OP_MOVE_NEXT, 1'($urandom_range(0, 1)));
         walks_done++;
      end
      steady = 1'b0;
   endtask

   // Arbitrary register contents, degenerate frames and any opcode.
   task automatic test_random_settings(input int phases);
      for (int p = 0; p < phases; p++) begin
         wait_drained();
         for (int idx = 0; idx < 8; idx++) begin
            if (p == 0 || $urandom_range(0, 3) != 0) begin
               if (idx == CSR_BLOCK_WIDTH || idx == CSR_BLOCK_HEIGHT)
                  csr_write(idx[CSR_IDX_W-1:0], pick_block_raw());
               else
                  csr_write(idx[CSR_IDX_W-1:0], pick_coord());
            end
         end
         repeat ($urandom_range(15, 25))
            send_step(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      steady = 1'b0;
      cycle_count = 0;
      errors = 0;
      items_sent = 0;
      results_checked = 0;
      csr_writes = 0;
      walks_done = 0;
      frame_cfg = '0;
      frame_cfg.block_width = BLOCK_W_RESET;
      frame_cfg.block_height = BLOCK_H_RESET;
      frame_cfg.orientation_mode = ORIENT_NORMAL;
      walk_pos = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_extremes();
      test_scan_walks(330);
      test_random_settings(6);

      wait_drained();
      repeat (5) @(negedge clock);
      $display("run covered %0d steps, %0d scans and %0d register writes over all eight",
               items_sent, walks_done, csr_writes);
      $display("orientations, with %0d responses compared and %0d mismatches",
               results_checked, errors);
      if (errors == 0) begin
         $display("** oriented_block_scan_stepper_unit: PASSED **");
      end else begin
         $display("** oriented_block_scan_stepper_unit: FAILED **");
      end
      $finish;
   end

endmodule

[filelist.f]
design/obss_pkg.sv
design/obss_step.sv
design/obss_rsp_skid.sv
design/oriented_block_scan_stepper_unit.sv
tb/tb_oriented_block_scan_stepper_unit.sv
